// ----- rtl/nsr_pkg.sv -----
// ----------------------------------------------------------------------------
// nsr_pkg
// Shared widths, register indexes, geometry record and slice helpers for the
// nine-slice rectangle generator.
// ----------------------------------------------------------------------------
package nsr_pkg;

  localparam int PX_W       = 12;
  localparam int Q_W        = 20;
  localparam int FRAME_W    = 16;
  localparam int MRG_W      = 21;
  localparam int SLICES     = 9;
  localparam int IDX_W      = 4;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 21;

  // divider: 40-bit dividend, 24-bit divisor, 21 quotient bits, one per stage
  localparam int DVD_W      = 40;
  localparam int DVS_W      = 24;
  localparam int QUO_W      = 21;
  localparam int DIV_STAGES = QUO_W;

  // x / 3 as (x * ceil(2^21 / 3)) >> 21, exact for x below 2^21
  localparam int          THIRD_SHIFT = 21;
  localparam logic [19:0] THIRD_MUL   = 20'hAAAAB;

  localparam logic [CFG_IDX_W-1:0] REG_TEX_W  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_H  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_W = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_H = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MRG_L  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MRG_R  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MRG_T  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MRG_B  = 4'd7;

  // config-side division operations, issued one per cycle
  localparam int          NUM_OPS    = 6;
  localparam logic [2:0]  OP_PER_ROW = 3'd0;
  localparam logic [2:0]  OP_ROWS    = 3'd1;
  localparam logic [2:0]  OP_ML      = 3'd2;
  localparam logic [2:0]  OP_MR      = 3'd3;
  localparam logic [2:0]  OP_MT      = 3'd4;
  localparam logic [2:0]  OP_MB      = 3'd5;

  localparam int                STEP_W    = $clog2(DIV_STAGES + NUM_OPS);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STAGES + NUM_OPS - 1);

  typedef enum logic [2:0] {
    CS_PREP,
    CS_MUL,
    CS_RUN,
    CS_FINISH,
    CS_READY
  } cfg_state_t;

  typedef struct packed {
    logic              tex_on;
    logic              atlas;
    logic [PX_W-1:0]   fw;
    logic [PX_W-1:0]   fh;
    logic [PX_W-1:0]   per_row;
    logic [DVS_W-1:0]  frames;
    logic [Q_W-1:0]    ml;
    logic [Q_W-1:0]    mr;
    logic [Q_W-1:0]    mt;
    logic [Q_W-1:0]    mb;
    logic [Q_W-1:0]    shs;
    logic [Q_W-1:0]    svs;
    logic [MRG_W-1:0]  hsum;
    logic [MRG_W-1:0]  vsum;
  } geom_t;

  function automatic logic [IDX_W-1:0] lowest_slice(input logic [SLICES-1:0] m);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = SLICES - 1; i >= 0; i--) begin
      if (m[i]) idx = IDX_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [1:0] slice_row(input logic [IDX_W-1:0] idx);
    logic [1:0] r;
    case (idx) inside
      [4'd0:4'd2]: r = 2'd0;
      [4'd3:4'd5]: r = 2'd1;
      default:     r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] slice_col(input logic [IDX_W-1:0] idx);
    logic [1:0] c;
    case (idx) inside
      4'd0, 4'd3, 4'd6: c = 2'd0;
      4'd1, 4'd4, 4'd7: c = 2'd1;
      default:          c = 2'd2;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/nine_slice_rect_generator.sv -----
// ----------------------------------------------------------------------------
// nine_slice_rect_generator
// Cuts one atlas frame into up to nine source/destination rectangle pairs
// (Q12.8) for a requested frame number and target size.
// ----------------------------------------------------------------------------
// A request passes a 46-stage pipeline (input and product registers, a
// 21-stage divider for the frame wrap and destination margin fit, a 21-stage
// divider for the atlas row/column, offset multiply, slice assembly). Its
// slices leave one per cycle from the slice register through the output
// registers, so the pipeline is held while more than one of a request's
// non-empty slices (0 to 9) is left; busy stays high while that register
// still has more than one slice to send. Results cannot be held off: every
// slice_valid cycle must be taken. After reset and after every configuration
// write, busy stays high while frame geometry and source margins are
// recomputed through a shared divider.
module nine_slice_rect_generator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [nsr_pkg::FRAME_W-1:0]    frame_index,
  input  logic [nsr_pkg::PX_W-1:0]       target_width,
  input  logic [nsr_pkg::PX_W-1:0]       target_height,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [nsr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nsr_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           slice_valid,
  output logic [nsr_pkg::IDX_W-1:0]      slice_index,
  output logic [nsr_pkg::Q_W-1:0]        src_x,
  output logic [nsr_pkg::Q_W-1:0]        src_y,
  output logic [nsr_pkg::Q_W-1:0]        src_w,
  output logic [nsr_pkg::Q_W-1:0]        src_h,
  output logic [nsr_pkg::Q_W-1:0]        dst_x,
  output logic [nsr_pkg::Q_W-1:0]        dst_y,
  output logic [nsr_pkg::Q_W-1:0]        dst_w,
  output logic [nsr_pkg::Q_W-1:0]        dst_h,
  output logic                           last_slice
);

  typedef struct packed {
    logic [nsr_pkg::Q_W-1:0] tw;
    logic [nsr_pkg::Q_W-1:0] th;
    logic                    hfit;
    logic                    vfit;
  } ctx_a_t;

  typedef struct packed {
    logic [nsr_pkg::Q_W-1:0] dml;
    logic [nsr_pkg::Q_W-1:0] dmr;
    logic [nsr_pkg::Q_W-1:0] dmt;
    logic [nsr_pkg::Q_W-1:0] dmb;
    logic [nsr_pkg::Q_W-1:0] dhs;
    logic [nsr_pkg::Q_W-1:0] dvs;
  } ctx_b_t;

  nsr_pkg::geom_t geom;
  logic           geom_ok;
  logic           en, accept;

  // P0
  logic                        v0;
  logic [nsr_pkg::FRAME_W-1:0] frame0;
  logic [nsr_pkg::PX_W-1:0]    tw0, th0;
  // P1
  logic                        v1;
  logic [nsr_pkg::FRAME_W-1:0] frame1;
  logic [nsr_pkg::DVD_W-1:0]   pl, pr, pt, pb;
  ctx_a_t                      ctx1;
  logic [nsr_pkg::Q_W-1:0]     tw0q, th0q;
  // divider A
  ctx_a_t                      ctx_a [nsr_pkg::DIV_STAGES];
  logic                        va;
  logic [nsr_pkg::QUO_W-1:0]   qf, ql, qr, qt, qb;
  logic [nsr_pkg::DVS_W-1:0]   rf, rl_unused, rr_unused, rt_unused, rb_unused;
  ctx_a_t                      ca;
  ctx_b_t                      cb_in;
  // divider B
  ctx_b_t                      ctx_b [nsr_pkg::DIV_STAGES];
  logic                        vb;
  logic [nsr_pkg::QUO_W-1:0]   qrow;
  logic [nsr_pkg::DVS_W-1:0]   rcol;
  // P2
  logic                        v2;
  logic [nsr_pkg::PX_W-1:0]    ax2, ay2;
  ctx_b_t                      c2;
  logic [2*nsr_pkg::PX_W-1:0]  axp, ayp;
  // P3 / slice register
  logic [nsr_pkg::SLICES-1:0]  mask, mask_new, mask_rest;
  logic [nsr_pkg::Q_W-1:0]     sx [3], sy [3], sw [3], sh [3];
  logic [nsr_pkg::Q_W-1:0]     dx [3], dy [3], dw [3], dh [3];
  logic [nsr_pkg::Q_W-1:0]     sx_n [3], sy_n [3], sw_n [3], sh_n [3];
  logic [nsr_pkg::Q_W-1:0]     dx_n [3], dy_n [3], dw_n [3], dh_n [3];
  logic [nsr_pkg::IDX_W-1:0]   sel;
  logic [1:0]                  sel_r, sel_c;

  nsr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom),
    .geom_ok   (geom_ok)
  );

  assign cfg_ready = 1'b1;

  assign mask_rest = mask & (mask - nsr_pkg::SLICES'(1));
  assign en        = (mask_rest == '0);
  assign busy      = !geom_ok || !en;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v0 <= accept;
      v1 <= v0;
      v2 <= vb;
    end
    if (en) begin
      frame0 <= frame_index;
      tw0    <= target_width;
      th0    <= target_height;
    end
  end

  assign tw0q = {tw0, 8'b0};
  assign th0q = {th0, 8'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      frame1    <= frame0;
      pl        <= nsr_pkg::DVD_W'(geom.ml) * nsr_pkg::DVD_W'(tw0q);
      pr        <= nsr_pkg::DVD_W'(geom.mr) * nsr_pkg::DVD_W'(tw0q);
      pt        <= nsr_pkg::DVD_W'(geom.mt) * nsr_pkg::DVD_W'(th0q);
      pb        <= nsr_pkg::DVD_W'(geom.mb) * nsr_pkg::DVD_W'(th0q);
      ctx1.tw   <= tw0q;
      ctx1.th   <= th0q;
      ctx1.hfit <= geom.hsum > nsr_pkg::MRG_W'(tw0q);
      ctx1.vfit <= geom.vsum > nsr_pkg::MRG_W'(th0q);
    end
  end

  nsr_div u_div_frame (
    .clk (clk), .rst (rst), .en (en), .vld_in (v1),
    .dividend (nsr_pkg::DVD_W'(frame1)), .divisor (geom.frames),
    .vld_out (va), .quot (qf), .rem (rf)
  );
  nsr_div u_div_ml (
    .clk (clk), .rst (rst), .en (en), .vld_in (v1),
    .dividend (pl), .divisor (nsr_pkg::DVS_W'(geom.hsum)),
    .vld_out (), .quot (ql), .rem (rl_unused)
  );
  nsr_div u_div_mr (
    .clk (clk), .rst (rst), .en (en), .vld_in (v1),
    .dividend (pr), .divisor (nsr_pkg::DVS_W'(geom.hsum)),
    .vld_out (), .quot (qr), .rem (rr_unused)
  );
  nsr_div u_div_mt (
    .clk (clk), .rst (rst), .en (en), .vld_in (v1),
    .dividend (pt), .divisor (nsr_pkg::DVS_W'(geom.vsum)),
    .vld_out (), .quot (qt), .rem (rt_unused)
  );
  nsr_div u_div_mb (
    .clk (clk), .rst (rst), .en (en), .vld_in (v1),
    .dividend (pb), .divisor (nsr_pkg::DVS_W'(geom.vsum)),
    .vld_out (), .quot (qb), .rem (rb_unused)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_a[0] <= ctx1;
      for (int i = 1; i < nsr_pkg::DIV_STAGES; i++) ctx_a[i] <= ctx_a[i-1];
      ctx_b[0] <= cb_in;
      for (int i = 1; i < nsr_pkg::DIV_STAGES; i++) ctx_b[i] <= ctx_b[i-1];
    end
  end

  assign ca = ctx_a[nsr_pkg::DIV_STAGES-1];

  always_comb begin
    cb_in.dml = ca.hfit ? ql[nsr_pkg::Q_W-1:0] : geom.ml;
    cb_in.dmr = ca.hfit ? qr[nsr_pkg::Q_W-1:0] : geom.mr;
    cb_in.dmt = ca.vfit ? qt[nsr_pkg::Q_W-1:0] : geom.mt;
    cb_in.dmb = ca.vfit ? qb[nsr_pkg::Q_W-1:0] : geom.mb;
    cb_in.dhs = ca.hfit ? '0 : nsr_pkg::Q_W'(nsr_pkg::MRG_W'(ca.tw) - geom.hsum);
    cb_in.dvs = ca.vfit ? '0 : nsr_pkg::Q_W'(nsr_pkg::MRG_W'(ca.th) - geom.vsum);
  end

  nsr_div u_div_row (
    .clk (clk), .rst (rst), .en (en), .vld_in (va),
    .dividend (nsr_pkg::DVD_W'(rf[nsr_pkg::FRAME_W-1:0])),
    .divisor (nsr_pkg::DVS_W'(geom.per_row)),
    .vld_out (vb), .quot (qrow), .rem (rcol)
  );

  // only the low 12 pixel bits survive the Q12.8 wrap
  assign axp = rcol[nsr_pkg::PX_W-1:0] * geom.fw;
  assign ayp = qrow[nsr_pkg::PX_W-1:0] * geom.fh;

  always_ff @(posedge clk) begin
    if (en) begin
      ax2 <= geom.atlas ? axp[nsr_pkg::PX_W-1:0] : '0;
      ay2 <= geom.atlas ? ayp[nsr_pkg::PX_W-1:0] : '0;
      c2  <= ctx_b[nsr_pkg::DIV_STAGES-1];
    end
  end

  always_comb begin
    sx_n[0] = {ax2, 8'b0};
    sx_n[1] = sx_n[0] + geom.ml;
    sx_n[2] = sx_n[1] + geom.shs;
    sw_n[0] = geom.ml;
    sw_n[1] = geom.shs;
    sw_n[2] = geom.mr;
    sy_n[0] = {ay2, 8'b0};
    sy_n[1] = sy_n[0] + geom.mt;
    sy_n[2] = sy_n[1] + geom.svs;
    sh_n[0] = geom.mt;
    sh_n[1] = geom.svs;
    sh_n[2] = geom.mb;
    dx_n[0] = '0;
    dx_n[1] = c2.dml;
    dx_n[2] = c2.dml + c2.dhs;
    dw_n[0] = c2.dml;
    dw_n[1] = c2.dhs;
    dw_n[2] = c2.dmr;
    dy_n[0] = '0;
    dy_n[1] = c2.dmt;
    dy_n[2] = c2.dmt + c2.dvs;
    dh_n[0] = c2.dmt;
    dh_n[1] = c2.dvs;
    dh_n[2] = c2.dmb;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        mask_new[r*3+c] = v2 && geom.tex_on
                          && (sw_n[c] != '0) && (sh_n[r] != '0)
                          && (dw_n[c] != '0) && (dh_n[r] != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (en) begin
      mask <= mask_new;
    end else begin
      mask <= mask_rest;
    end
    if (en) begin
      sx <= sx_n;
      sy <= sy_n;
      sw <= sw_n;
      sh <= sh_n;
      dx <= dx_n;
      dy <= dy_n;
      dw <= dw_n;
      dh <= dh_n;
    end
  end

  assign sel   = nsr_pkg::lowest_slice(mask);
  assign sel_r = nsr_pkg::slice_row(sel);
  assign sel_c = nsr_pkg::slice_col(sel);

  always_ff @(posedge clk) begin
    if (rst) begin
      slice_valid <= 1'b0;
    end else begin
      slice_valid <= (mask != '0);
    end
    slice_index <= sel;
    src_x       <= sx[sel_c];
    src_y       <= sy[sel_r];
    src_w       <= sw[sel_c];
    src_h       <= sh[sel_r];
    dst_x       <= dx[sel_c];
    dst_y       <= dy[sel_r];
    dst_w       <= dw[sel_c];
    dst_h       <= dh[sel_r];
    last_slice  <= (mask_rest == '0);
  end

  // a request's slices leave in consecutive cycles
  a_slice_run: assert property (@(posedge clk) disable iff (rst)
    slice_valid && !last_slice |=> slice_valid)
    else $error("slice run broken before last slice");

  // within a request slice numbers strictly increase
  a_slice_order: assert property (@(posedge clk) disable iff (rst)
    slice_valid && $past(slice_valid) && !$past(last_slice)
      |-> slice_index > $past(slice_index))
    else $error("slice order violated");

  a_slice_range: assert property (@(posedge clk) disable iff (rst)
    slice_valid |-> slice_index <= 4'd8)
    else $error("slice index out of range");

endmodule

// ----- rtl/nsr_div.sv -----
// ----------------------------------------------------------------------------
// nsr_div
// Pipelined restoring divider, one quotient bit per stage, with stall enable.
// Needs dividend < divisor * 2^QUO_W.
// ----------------------------------------------------------------------------
module nsr_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       vld_in,
  input  logic [nsr_pkg::DVD_W-1:0]  dividend,
  input  logic [nsr_pkg::DVS_W-1:0]  divisor,
  output logic                       vld_out,
  output logic [nsr_pkg::QUO_W-1:0]  quot,
  output logic [nsr_pkg::DVS_W-1:0]  rem
);

  localparam int WIDE = nsr_pkg::DVD_W + nsr_pkg::DVS_W;

  logic [nsr_pkg::DVD_W-1:0] r [nsr_pkg::DIV_STAGES];
  logic [nsr_pkg::DVS_W-1:0] d [nsr_pkg::DIV_STAGES];
  logic [nsr_pkg::QUO_W-1:0] q [nsr_pkg::DIV_STAGES];
  logic                      v [nsr_pkg::DIV_STAGES];

  for (genvar k = 0; k < nsr_pkg::DIV_STAGES; k++) begin : g_stage
    localparam int B = nsr_pkg::QUO_W - 1 - k;
    logic [nsr_pkg::DVD_W-1:0] r_in;
    logic [nsr_pkg::DVS_W-1:0] d_in;
    logic [nsr_pkg::QUO_W-1:0] q_in;
    logic                      v_in;
    logic [WIDE-1:0]           sub;
    logic                      take;

    if (k == 0) begin : g_first
      assign r_in = dividend;
      assign d_in = divisor;
      assign q_in = '0;
      assign v_in = vld_in;
    end else begin : g_next
      assign r_in = r[k-1];
      assign d_in = d[k-1];
      assign q_in = q[k-1];
      assign v_in = v[k-1];
    end

    assign sub  = WIDE'(d_in) << B;
    assign take = WIDE'(r_in) >= sub;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= v_in;
      end
      if (en) begin
        r[k] <= take ? r_in - sub[nsr_pkg::DVD_W-1:0] : r_in;
        d[k] <= d_in;
        q[k] <= q_in | (take ? (nsr_pkg::QUO_W'(1) << B) : '0);
      end
    end
  end

  assign vld_out = v[nsr_pkg::DIV_STAGES-1];
  assign quot    = q[nsr_pkg::DIV_STAGES-1];
  assign rem     = r[nsr_pkg::DIV_STAGES-1][nsr_pkg::DVS_W-1:0];

endmodule

// ----- rtl/nsr_cfg.sv -----
// ----------------------------------------------------------------------------
// nsr_cfg
// Configuration registers and the sequencer that derives frame geometry and
// fitted source margins after reset and after every register write.
// ----------------------------------------------------------------------------
module nsr_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic [nsr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nsr_pkg::CFG_DATA_W-1:0] cfg_data,
  output nsr_pkg::geom_t                 geom,
  output logic                           geom_ok
);

  logic [nsr_pkg::PX_W-1:0]  tw, th, cw, ch;
  logic [nsr_pkg::MRG_W-1:0] mraw [4];

  nsr_pkg::cfg_state_t state, state_next;
  logic [nsr_pkg::STEP_W-1:0] step;

  logic [nsr_pkg::PX_W-1:0]  fw, fh;
  logic [nsr_pkg::Q_W-1:0]   mv [4];
  logic [nsr_pkg::DVD_W-1:0] prod [4];
  logic [nsr_pkg::MRG_W-1:0] hsum, vsum;
  logic                      hfit, vfit;
  logic [nsr_pkg::QUO_W-1:0] res [nsr_pkg::NUM_OPS];

  logic [nsr_pkg::PX_W-1:0]  fw_c, fh_c;
  logic [nsr_pkg::Q_W-1:0]   fwt_c, fht_c, fwt, fht;
  logic [39:0]               third_w, third_h;
  logic [nsr_pkg::Q_W-1:0]   mv_c [4];

  logic [nsr_pkg::DVD_W-1:0] dvd;
  logic [nsr_pkg::DVS_W-1:0] dvs;
  logic [nsr_pkg::QUO_W-1:0] quot;
  logic [nsr_pkg::DVS_W-1:0] rem_unused;
  logic [nsr_pkg::STEP_W-1:0] res_step;

  logic [nsr_pkg::PX_W-1:0]  pr, rw;
  logic [nsr_pkg::DVS_W-1:0] frames_raw;
  logic [nsr_pkg::Q_W-1:0]   fl, fr, ft, fb;
  logic [nsr_pkg::MRG_W-1:0] hs_fit, vs_fit;

  assign fw_c  = (cw != '0) ? cw : tw;
  assign fh_c  = (ch != '0) ? ch : th;
  assign fwt_c = {fw_c, 8'b0};
  assign fht_c = {fh_c, 8'b0};
  assign fwt   = {fw, 8'b0};
  assign fht   = {fh, 8'b0};

  assign third_w = 40'(fwt_c) * 40'(nsr_pkg::THIRD_MUL);
  assign third_h = 40'(fht_c) * 40'(nsr_pkg::THIRD_MUL);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (mraw[i][nsr_pkg::MRG_W-1]) begin
        mv_c[i] = (i < 2) ? nsr_pkg::Q_W'(third_w >> nsr_pkg::THIRD_SHIFT)
                          : nsr_pkg::Q_W'(third_h >> nsr_pkg::THIRD_SHIFT);
      end else begin
        mv_c[i] = mraw[i][nsr_pkg::Q_W-1:0];
      end
    end
  end

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      tw <= '0;
      th <= '0;
      cw <= '0;
      ch <= '0;
      for (int i = 0; i < 4; i++) mraw[i] <= '1;
    end else if (cfg_valid) begin
      case (cfg_index)
        nsr_pkg::REG_TEX_W:  tw <= cfg_data[nsr_pkg::PX_W-1:0];
        nsr_pkg::REG_TEX_H:  th <= cfg_data[nsr_pkg::PX_W-1:0];
        nsr_pkg::REG_CELL_W: cw <= cfg_data[nsr_pkg::PX_W-1:0];
        nsr_pkg::REG_CELL_H: ch <= cfg_data[nsr_pkg::PX_W-1:0];
        nsr_pkg::REG_MRG_L:  mraw[0] <= cfg_data;
        nsr_pkg::REG_MRG_R:  mraw[1] <= cfg_data;
        nsr_pkg::REG_MRG_T:  mraw[2] <= cfg_data;
        nsr_pkg::REG_MRG_B:  mraw[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nsr_pkg::CS_PREP;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      nsr_pkg::CS_PREP:   state_next = nsr_pkg::CS_MUL;
      nsr_pkg::CS_MUL:    state_next = nsr_pkg::CS_RUN;
      nsr_pkg::CS_RUN: begin
        if (step == nsr_pkg::STEP_LAST) state_next = nsr_pkg::CS_FINISH;
      end
      nsr_pkg::CS_FINISH: state_next = nsr_pkg::CS_READY;
      nsr_pkg::CS_READY:  state_next = nsr_pkg::CS_READY;
      default:            state_next = nsr_pkg::CS_PREP;
    endcase
    if (cfg_valid) state_next = nsr_pkg::CS_PREP;
  end

  assign geom_ok = (state == nsr_pkg::CS_READY);

  // one op per cycle in; each op's quotient is stored into res under its op index as it leaves the divider
  always_comb begin
    dvd = '0;
    dvs = '0;
    case (step[2:0])
      nsr_pkg::OP_PER_ROW: begin
        dvd = nsr_pkg::DVD_W'(tw);
        dvs = nsr_pkg::DVS_W'(fw);
      end
      nsr_pkg::OP_ROWS: begin
        dvd = nsr_pkg::DVD_W'(th);
        dvs = nsr_pkg::DVS_W'(fh);
      end
      nsr_pkg::OP_ML: begin
        dvd = prod[0];
        dvs = nsr_pkg::DVS_W'(hsum);
      end
      nsr_pkg::OP_MR: begin
        dvd = prod[1];
        dvs = nsr_pkg::DVS_W'(hsum);
      end
      nsr_pkg::OP_MT: begin
        dvd = prod[2];
        dvs = nsr_pkg::DVS_W'(vsum);
      end
      nsr_pkg::OP_MB: begin
        dvd = prod[3];
        dvs = nsr_pkg::DVS_W'(vsum);
      end
      default: ;
    endcase
  end

  nsr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (1'b1),
    .vld_in   (1'b1),
    .dividend (dvd),
    .divisor  (dvs),
    .vld_out  (),
    .quot     (quot),
    .rem      (rem_unused)
  );

  assign res_step = step - nsr_pkg::STEP_W'(nsr_pkg::DIV_STAGES);

  assign pr         = res[nsr_pkg::OP_PER_ROW][nsr_pkg::PX_W-1:0];
  assign rw         = res[nsr_pkg::OP_ROWS][nsr_pkg::PX_W-1:0];
  assign frames_raw = nsr_pkg::DVS_W'(pr) * nsr_pkg::DVS_W'(rw);
  assign fl = hfit ? res[nsr_pkg::OP_ML][nsr_pkg::Q_W-1:0] : mv[0];
  assign fr = hfit ? res[nsr_pkg::OP_MR][nsr_pkg::Q_W-1:0] : mv[1];
  assign ft = vfit ? res[nsr_pkg::OP_MT][nsr_pkg::Q_W-1:0] : mv[2];
  assign fb = vfit ? res[nsr_pkg::OP_MB][nsr_pkg::Q_W-1:0] : mv[3];
  assign hs_fit = nsr_pkg::MRG_W'(fl) + nsr_pkg::MRG_W'(fr);
  assign vs_fit = nsr_pkg::MRG_W'(ft) + nsr_pkg::MRG_W'(fb);

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (state == nsr_pkg::CS_RUN && !cfg_valid) begin
      step <= step + nsr_pkg::STEP_W'(1);
    end else begin
      step <= '0;
    end

    case (state)
      nsr_pkg::CS_PREP: begin
        fw <= fw_c;
        fh <= fh_c;
        for (int i = 0; i < 4; i++) mv[i] <= mv_c[i];
      end
      nsr_pkg::CS_MUL: begin
        prod[0] <= nsr_pkg::DVD_W'(mv[0]) * nsr_pkg::DVD_W'(fwt);
        prod[1] <= nsr_pkg::DVD_W'(mv[1]) * nsr_pkg::DVD_W'(fwt);
        prod[2] <= nsr_pkg::DVD_W'(mv[2]) * nsr_pkg::DVD_W'(fht);
        prod[3] <= nsr_pkg::DVD_W'(mv[3]) * nsr_pkg::DVD_W'(fht);
        hsum    <= nsr_pkg::MRG_W'(mv[0]) + nsr_pkg::MRG_W'(mv[1]);
        vsum    <= nsr_pkg::MRG_W'(mv[2]) + nsr_pkg::MRG_W'(mv[3]);
        hfit    <= (nsr_pkg::MRG_W'(mv[0]) + nsr_pkg::MRG_W'(mv[1])) > nsr_pkg::MRG_W'(fwt);
        vfit    <= (nsr_pkg::MRG_W'(mv[2]) + nsr_pkg::MRG_W'(mv[3])) > nsr_pkg::MRG_W'(fht);
      end
      nsr_pkg::CS_RUN: begin
        if (step >= nsr_pkg::STEP_W'(nsr_pkg::DIV_STAGES)) begin
          res[res_step[2:0]] <= quot;
        end
      end
      nsr_pkg::CS_FINISH: begin
        geom.tex_on  <= (tw != '0);
        geom.atlas   <= (cw != '0) && (ch != '0);
        geom.fw      <= fw;
        geom.fh      <= fh;
        geom.per_row <= (pr == '0) ? nsr_pkg::PX_W'(1) : pr;
        geom.frames  <= (frames_raw == '0) ? nsr_pkg::DVS_W'(1) : frames_raw;
        geom.ml      <= fl;
        geom.mr      <= fr;
        geom.mt      <= ft;
        geom.mb      <= fb;
        geom.hsum    <= hs_fit;
        geom.vsum    <= vs_fit;
        geom.shs     <= nsr_pkg::Q_W'(nsr_pkg::MRG_W'(fwt) - hs_fit);
        geom.svs     <= nsr_pkg::Q_W'(nsr_pkg::MRG_W'(fht) - vs_fit);
      end
      default: ;
    endcase
  end

endmodule
